[hw/rtl/isi_pkg.sv]
// Shared types and constants for the interval set insert block.
package isi_pkg;

   localparam int NumberBits = 32;
   localparam int StatusBits = 3;
   localparam int CountBits  = 5;

   typedef enum logic [StatusBits-1:0] {
      STATUS_PRESENT  = 3'd0,
      STATUS_EXTENDED = 3'd1,
      STATUS_INSERTED = 3'd2,
      STATUS_MERGED   = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EVAL  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic evaluate;
      logic commit;
   } cmd_type;

endpackage

[hw/rtl/isi_ctrl.sv]
// Controller state machine that sequences capture, evaluation and commit of each insert.
module isi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output isi_pkg::cmd_type cmd
);

   isi_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               commit;
   logic               accept_ok;
   logic               capture;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == isi_pkg::ST_APPLY) && out_free;
   assign accept_ok = (state_ff == isi_pkg::ST_IDLE) || commit;
   assign capture   = req_valid && accept_ok;
   assign req_stall = !accept_ok;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture  = capture;
   assign cmd.evaluate = (state_ff == isi_pkg::ST_EVAL);
   assign cmd.commit   = commit;

   always_comb begin
      unique case (state_ff)
         isi_pkg::ST_IDLE: begin
            state_in = capture ? isi_pkg::ST_EVAL : isi_pkg::ST_IDLE;
         end
         isi_pkg::ST_EVAL: begin
            state_in = isi_pkg::ST_APPLY;
         end
         isi_pkg::ST_APPLY: begin
            if (commit) begin
               state_in = capture ? isi_pkg::ST_EVAL : isi_pkg::ST_IDLE;
            end else begin
               state_in = isi_pkg::ST_APPLY;
            end
         end
         default: begin
            state_in = isi_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_rsp_after_commit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("result transaction appeared without a commit");

   a_eval_to_apply : assert property (@(posedge clock) disable iff (reset)
      (state_ff == isi_pkg::ST_EVAL) |=> (state_ff == isi_pkg::ST_APPLY))
      else $error("evaluation was not followed by the apply step");

   a_capture_then_eval : assert property (@(posedge clock) disable iff (reset)
      capture |=> (state_ff == isi_pkg::ST_EVAL))
      else $error("accepted transaction did not start evaluation");
`endif

endmodule

[hw/rtl/isi_dpath.sv]
// Datapath holding the sorted range table, the per-entry comparators and the result register.
module isi_dpath #(
   parameter int MAX_RANGES = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  isi_pkg::cmd_type                     cmd,
   input  logic signed [isi_pkg::NumberBits-1:0] req_number,
   output logic [isi_pkg::StatusBits-1:0]       rsp_status,
   output logic [isi_pkg::CountBits-1:0]        rsp_range_count
);

   localparam int CntW = $clog2(MAX_RANGES + 1);
   localparam logic [VALUE_BITS-1:0] SignMask = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [VALUE_BITS-1:0] low_ff  [MAX_RANGES];
   logic [VALUE_BITS-1:0] high_ff [MAX_RANGES];
   logic [CntW-1:0]       used_ff, used_in;

   logic [VALUE_BITS-1:0] key_new;
   logic [VALUE_BITS-1:0] key_ff, key_inc_ff, key_dec_ff;
   logic                  key_top_ff, key_bot_ff;

   logic [MAX_RANGES-1:0] ev_in, hit_in, lo_adj_in, hi_adj_in;
   logic [MAX_RANGES-1:0] ev_ff, hit_ff, lo_adj_ff, hi_adj_ff;
   logic [MAX_RANGES-1:0] first, after, place, merge_vec;

   logic hit_any, lo_any, hi_any, merge_any, none, full, do_insert;

   isi_pkg::status_type             status_in, status_ff;
   logic [isi_pkg::CountBits-1:0]   count_ff;

   // Biased key: flipping the sign bit makes unsigned order equal signed order.
   assign key_new = VALUE_BITS'(req_number) ^ SignMask;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff     <= key_new;
         key_inc_ff <= key_new + VALUE_BITS'(1);
         key_dec_ff <= key_new - VALUE_BITS'(1);
         key_top_ff <= &key_new;
         key_bot_ff <= ~|key_new;
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_RANGES; g++) begin : g_entry
         logic                  valid;
         logic [VALUE_BITS-1:0] low_in, high_in;

         assign valid        = CntW'(g) < used_ff;
         assign hit_in[g]    = valid && (low_ff[g] <= key_ff) && (key_ff <= high_ff[g]);
         assign lo_adj_in[g] = valid && !key_top_ff && (low_ff[g] == key_inc_ff);
         assign hi_adj_in[g] = valid && !key_bot_ff && (high_ff[g] == key_dec_ff);
         assign ev_in[g]     = valid && ((high_ff[g] >= key_ff) || hi_adj_in[g]);

         if (g == 0) begin : g_head
            assign first[g] = ev_ff[g];
            assign after[g] = 1'b0;
         end else begin : g_body
            assign first[g] = ev_ff[g] & ~ev_ff[g-1];
            assign after[g] = ev_ff[g-1];
         end

         if (g < MAX_RANGES - 1) begin : g_merge
            assign merge_vec[g] = first[g] & hi_adj_ff[g] & lo_adj_ff[g+1];
         end else begin : g_nomerge
            assign merge_vec[g] = 1'b0;
         end

         assign place[g] = first[g] | (none & (CntW'(g) == used_ff));

         always_comb begin
            low_in  = low_ff[g];
            high_in = high_ff[g];
            if (lo_any && first[g]) begin
               low_in = key_ff;
            end
            if (hi_any && !merge_any && first[g]) begin
               high_in = key_ff;
            end
            if (do_insert && place[g]) begin
               low_in  = key_ff;
               high_in = key_ff;
            end
            if (g > 0) begin
               if (do_insert && after[g]) begin
                  low_in  = low_ff[(g > 0) ? g - 1 : 0];
                  high_in = high_ff[(g > 0) ? g - 1 : 0];
               end
            end
            if (g < MAX_RANGES - 1) begin
               if (merge_any && first[g]) begin
                  high_in = high_ff[(g < MAX_RANGES - 1) ? g + 1 : g];
               end
               if (merge_any && after[g]) begin
                  low_in  = low_ff[(g < MAX_RANGES - 1) ? g + 1 : g];
                  high_in = high_ff[(g < MAX_RANGES - 1) ? g + 1 : g];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (cmd.commit) begin
               low_ff[g]  <= low_in;
               high_ff[g] <= high_in;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         ev_ff     <= ev_in;
         hit_ff    <= hit_in;
         lo_adj_ff <= lo_adj_in;
         hi_adj_ff <= hi_adj_in;
      end
   end

   assign hit_any   = |(first & hit_ff);
   assign lo_any    = |(first & lo_adj_ff);
   assign hi_any    = |(first & hi_adj_ff);
   assign merge_any = |merge_vec;
   assign none      = ~|ev_ff;
   assign full      = (used_ff == CntW'(MAX_RANGES));
   assign do_insert = !hit_any && !lo_any && !hi_any && !full;

   always_comb begin
      used_in = used_ff;
      priority if (hit_any) begin
         status_in = isi_pkg::STATUS_PRESENT;
      end else if (lo_any) begin
         status_in = isi_pkg::STATUS_EXTENDED;
      end else if (merge_any) begin
         status_in = isi_pkg::STATUS_MERGED;
         used_in   = used_ff - CntW'(1);
      end else if (hi_any) begin
         status_in = isi_pkg::STATUS_EXTENDED;
      end else if (full) begin
         status_in = isi_pkg::STATUS_FULL;
      end else begin
         status_in = isi_pkg::STATUS_INSERTED;
         used_in   = used_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.commit) begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         count_ff  <= isi_pkg::CountBits'(used_in);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_range_count = count_ff;

`ifndef SYNTHESIS
   a_used_bounded : assert property (@(posedge clock) disable iff (reset)
      used_ff <= CntW'(MAX_RANGES))
      else $error("range count exceeds the table size");

   a_single_first : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot0(first))
      else $error("more than one entry selected for update");

   a_full_keeps_set : assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status_in == isi_pkg::STATUS_FULL) |=> (used_ff == $past(used_ff)))
      else $error("table full transaction changed the range count");
`endif

endmodule

[hw/rtl/interval_set_insert.sv]
// Top level of the interval set insert block: controller, datapath and ports.
// Keeps a set of signed numbers as a sorted table of disjoint, non-adjacent ranges of up to
// MAX_RANGES entries held in registers, and adds one number per request transaction. Each
// request gives one response: 0 already present, 1 range extended, 2 new range inserted,
// 3 two ranges merged, 4 table full (set left unchanged), with the low five bits of the range
// count after the insert. A request is accepted, its number is compared against every table
// entry in parallel in the next cycle, and the registered compare results then drive the
// shift and in-place update of the table when the request commits, which also loads the
// response into the output register. A new request can be accepted in the same cycle that the
// previous one commits, but not while that one is still being compared or waits to commit.
// The response waits in its register while the response side stalls, which holds off the next
// commit and with it the acceptance of any request after that one.
module interval_set_insert #(
   parameter int MAX_RANGES = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [isi_pkg::NumberBits-1:0] req_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [isi_pkg::StatusBits-1:0]        rsp_status,
   output logic [isi_pkg::CountBits-1:0]         rsp_range_count
);

   isi_pkg::cmd_type cmd;

   isi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   isi_dpath #(
      .MAX_RANGES (MAX_RANGES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_number      (req_number),
      .rsp_status      (rsp_status),
      .rsp_range_count (rsp_range_count)
   );

endmodule

[tb/tb.sv]
// Self-checking testbench for interval_set_insert with a built-in range table predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxRanges     = 16;
   localparam int WatchdogLimit = 5000;
   localparam int TailCycles    = 8;

   typedef struct {
      isi_pkg::status_type           status;
      logic [isi_pkg::CountBits-1:0] count;
   } outcome_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic signed [isi_pkg::NumberBits-1:0] req_number;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [isi_pkg::StatusBits-1:0]        rsp_status;
   logic [isi_pkg::CountBits-1:0]         rsp_range_count;

   logic signed [isi_pkg::NumberBits-1:0] set_lo [MaxRanges];
   logic signed [isi_pkg::NumberBits-1:0] set_hi [MaxRanges];
   int                                    set_used;

   outcome_type pending_outcomes [$];
   int          status_seen [5];
   int          mismatch_count;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;

   interval_set_insert dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_range_count(rsp_range_count)
   );

   always #6 clock = ~clock;

   function automatic void predict_insert(input logic signed [isi_pkg::NumberBits-1:0] num,
                                          output outcome_type result);
      longint n;
      longint lo;
      longint hi;
      int     pos;
      bit     done;
      n = num;
      pos = set_used;
      done = 1'b0;
      result.status = isi_pkg::STATUS_INSERTED;
      for (int i = 0; i < set_used && !done; i++) begin
         lo = set_lo[i];
         hi = set_hi[i];
         if (n >= lo && n <= hi) begin
            result.status = isi_pkg::STATUS_PRESENT;
            done = 1'b1;
         end else if (n == lo - 1) begin
            set_lo[i] = num;
            result.status = isi_pkg::STATUS_EXTENDED;
            done = 1'b1;
         end else if (n == hi + 1) begin
            set_hi[i] = num;
            result.status = isi_pkg::STATUS_EXTENDED;
            if (i + 1 < set_used && longint'(set_lo[i + 1]) == n + 1) begin
               set_hi[i] = set_hi[i + 1];
               for (int j = i + 1; j + 1 < set_used; j++) begin
                  set_lo[j] = set_lo[j + 1];
                  set_hi[j] = set_hi[j + 1];
               end
               set_used--;
               result.status = isi_pkg::STATUS_MERGED;
            end
            done = 1'b1;
         end else if (n < lo) begin
            pos = i;
            done = 1'b1;
         end
      end
      if (result.status == isi_pkg::STATUS_INSERTED) begin
         if (set_used >= MaxRanges) begin
            result.status = isi_pkg::STATUS_FULL;
         end else begin
            for (int j = set_used; j > pos; j--) begin
               set_lo[j] = set_lo[j - 1];
               set_hi[j] = set_hi[j - 1];
            end
            set_lo[pos] = num;
            set_hi[pos] = num;
            set_used++;
         end
      end
      result.count = isi_pkg::CountBits'(set_used);
   endfunction

   // Most picks land on or next to a stored range so that ranges grow and merge.
   function automatic logic signed [isi_pkg::NumberBits-1:0] pick_number(
         input logic signed [isi_pkg::NumberBits-1:0] base);
      int k;
      int roll;
      roll = $urandom_range(99);
      k = (set_used > 0) ? $urandom_range(set_used - 1) : 0;
      if (set_used == 0 || roll < 22) begin
         return base + $urandom_range(63);
      end else if (roll < 50) begin
         return set_lo[k] - 1;
      end else if (roll < 78) begin
         return set_hi[k] + 1;
      end else if (roll < 90) begin
         return $urandom_range(1) ? set_lo[k] : set_hi[k];
      end else if (roll < 95) begin
         if (set_used == MaxRanges) begin
            return $urandom;
         end
         return base + $urandom_range(63);
      end
      case ($urandom_range(3))
         0: return 32'h7fff_ffff;
         1: return 32'h7fff_fffe;
         2: return 32'h8000_0000;
         default: return 32'h8000_0001;
      endcase
   endfunction

   task automatic note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic send_number(input logic signed [isi_pkg::NumberBits-1:0] num);
      outcome_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_insert(num, want);
      pending_outcomes.push_back(want);
      req_valid <= 1'b1;
      req_number <= num;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_basic_outcomes();
      send_number(10);
      send_number(10);
      send_number(11);
      send_number(9);
      send_number(17);
      send_number(13);
      send_number(12);
      send_number(14);
      send_number(5);
      send_number(0);
   endtask

   task automatic test_value_extremes();
      send_number(32'h7fff_ffff);
      send_number(32'h7fff_fffe);
      send_number(32'h8000_0000);
      send_number(32'h8000_0001);
      send_number(32'h7fff_ffff);
   endtask

   task automatic test_table_full();
      for (int v = 30; v <= 120; v += 10) begin
         send_number(v);
      end
      send_number(200);
      send_number(15);
      send_number(16);
      send_number(200);
      send_number(-7);
   endtask

   task automatic test_random_inserts(input int items, input int send_pct, input int recv_pct,
                                      input logic signed [isi_pkg::NumberBits-1:0] region);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < items; i++) begin
         if (i == items / 2) begin
            wait_for_results();
         end
         send_number(pick_number(region + $urandom_range(511)));
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               note_error($sformatf("unexpected transaction: status %0d count %0d",
                                    rsp_status, rsp_range_count));
            end else begin
               want = pending_outcomes.pop_front();
               status_seen[int'(want.status)]++;
               if (rsp_status !== want.status) begin
                  note_error($sformatf("status expected %0d actual %0d",
                                       want.status, rsp_status));
               end
               if (rsp_range_count !== want.count) begin
                  note_error($sformatf("range_count expected %0d actual %0d",
                                       want.count, rsp_range_count));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
         $display("interval_set_insert test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_number = '0;
      rsp_stall = 1'b0;
      set_used = 0;
      mismatch_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_basic_outcomes();
      test_value_extremes();
      test_table_full();
      test_random_inserts(240, 29, 63, 0);
      test_random_inserts(230, 63, 29, 100000);
      test_random_inserts(230, 0, 0, -100000);

      wait_for_results();
      repeat (TailCycles) @(posedge clock);
      $display("Covered %0d present, %0d extended, %0d inserted, %0d merged, %0d full outcomes,",
               status_seen[isi_pkg::STATUS_PRESENT], status_seen[isi_pkg::STATUS_EXTENDED],
               status_seen[isi_pkg::STATUS_INSERTED], status_seen[isi_pkg::STATUS_MERGED],
               status_seen[isi_pkg::STATUS_FULL]);
      $display("under sender-heavy, receiver-heavy and gap-free traffic; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("interval_set_insert test passed");
      end else begin
         $display("interval_set_insert test failed");
      end
      $finish;
   end

endmodule
